// File: design/cf_pkg.sv
// ----------------------------------------------------------------------------
// cf_pkg
// Shared types and constants of the fixed-point 2D convolution engine.
// ----------------------------------------------------------------------------
package cf_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_STORE_ACT  = 2'd0,
    CMD_STORE_WGT  = 2'd1,
    CMD_STORE_BIAS = 2'd2,
    CMD_COMPUTE    = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTERS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FSIZE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAME     = 3'd6;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_FINISH
  } state_t;

  // accumulator width: bias plus up to 7x7x16 products of 32 bits
  localparam int unsigned ACC_W = 48;

endpackage

// File: design/cf_if.sv
// ----------------------------------------------------------------------------
// cf_if
// Valid/ready channel interfaces of the convolution engine.
// ----------------------------------------------------------------------------
interface cf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  row;
  logic [5:0]  column;
  logic [3:0]  channel;
  logic [3:0]  filter;
  logic [2:0]  tap_row;
  logic [2:0]  tap_column;
  logic signed [31:0] value;

  modport source (output valid, command, row, column, channel, filter, tap_row,
                  tap_column, value, input ready);
  modport sink (input valid, command, row, column, channel, filter, tap_row,
                tap_column, value, output ready);
endinterface

interface cf_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic signed [31:0] result;

  modport source (output valid, status, result, input ready);
  modport sink (input valid, status, result, output ready);
endinterface

interface cf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cf_pkg::CFG_IDX_W-1:0]  index;
  logic [cf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/cf_ram.sv
// ----------------------------------------------------------------------------
// cf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: design/conv2d_forward_unit.sv
// ----------------------------------------------------------------------------
// conv2d_forward_unit
// Fixed-point 2D convolution engine: stores activations, weights and biases
// in on-chip RAM and computes one output value per compute transaction.
// ----------------------------------------------------------------------------
// A store gives its result in the cycle after it is accepted. A compute
// walks filter_size^2 * input_channels taps (one MAC per cycle, bound by
// the single read port of each store) and then drains its pipeline; a bad
// request skips the taps. One transaction at a time.
// Reset (synchronous, rst_n low) restores the register defaults and idles
// the sequencer; RAM contents are undefined until written.
module conv2d_forward_unit #(
  parameter int unsigned MAX_HEIGHT      = 64,
  parameter int unsigned MAX_WIDTH       = 64,
  parameter int unsigned MAX_CHANNELS    = 16,
  parameter int unsigned MAX_FILTERS     = 16,
  parameter int unsigned MAX_FILTER_SIZE = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  cf_in_if.sink      in_chan,
  cf_out_if.source   out_chan,
  cf_cfg_if.sink     cfg_chan
);

  localparam int unsigned ACT_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned WGT_DEPTH =
    MAX_FILTERS * MAX_CHANNELS * MAX_FILTER_SIZE * MAX_FILTER_SIZE;
  localparam int unsigned ACT_AW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int unsigned WGT_AW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int unsigned BIAS_AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int unsigned H_CAP  = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
  localparam int unsigned W_CAP  = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int unsigned C_CAP  = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
  localparam int unsigned F_CAP  = (MAX_FILTERS < 16) ? MAX_FILTERS : 16;
  localparam int unsigned FS_CAP = (MAX_FILTER_SIZE < 7) ? MAX_FILTER_SIZE : 7;

  // configuration registers
  logic [6:0] height_r, width_r;
  logic [4:0] channels_r, filters_r;
  logic [2:0] fsize_r, stride_r;
  logic       same_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r   <= 7'd8;
      width_r    <= 7'd8;
      channels_r <= 5'd1;
      filters_r  <= 5'd1;
      fsize_r    <= 3'd3;
      stride_r   <= 3'd1;
      same_r     <= 1'b1;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        cf_pkg::REG_HEIGHT:   height_r   <= cfg_chan.data[6:0];
        cf_pkg::REG_WIDTH:    width_r    <= cfg_chan.data[6:0];
        cf_pkg::REG_CHANNELS: channels_r <= cfg_chan.data[4:0];
        cf_pkg::REG_FILTERS:  filters_r  <= cfg_chan.data[4:0];
        cf_pkg::REG_FSIZE:    fsize_r    <= cfg_chan.data[2:0];
        cf_pkg::REG_STRIDE:   stride_r   <= cfg_chan.data[2:0];
        cf_pkg::REG_SAME:     same_r     <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // clamped working values
  logic [6:0] h_c, w_c;
  logic [4:0] nc_c, nf_c;
  logic [2:0] fs_c, st_c, pad_c;

  always_comb begin
    h_c  = (height_r == 7'd0) ? 7'd1 :
           (32'(height_r) > H_CAP) ? 7'(H_CAP) : height_r;
    w_c  = (width_r == 7'd0) ? 7'd1 :
           (32'(width_r) > W_CAP) ? 7'(W_CAP) : width_r;
    nc_c = (channels_r == 5'd0) ? 5'd1 :
           (32'(channels_r) > C_CAP) ? 5'(C_CAP) : channels_r;
    nf_c = (filters_r == 5'd0) ? 5'd1 :
           (32'(filters_r) > F_CAP) ? 5'(F_CAP) : filters_r;
    fs_c = (fsize_r == 3'd0) ? 3'd1 :
           (32'(fsize_r) > FS_CAP) ? 3'(FS_CAP) : fsize_r;
    st_c = (stride_r == 3'd0) ? 3'd1 : stride_r;
    pad_c = same_r ? ((fs_c - 3'd1) >> 1) : 3'd0;
  end

  // sequencer registers
  cf_pkg::state_t state_r, state_nxt;
  logic [5:0]  row_r, col_r;
  logic [3:0]  flt_r;
  logic [9:0]  base_r_r, base_c_r;
  logic        bad_r;
  logic [4:0]  c_r;
  logic [2:0]  i_r, j_r;
  logic        bias_load_r;
  logic        v1_r, v2_r;
  logic signed [31:0] prod_r;
  logic signed [cf_pkg::ACC_W-1:0] acc_r;
  logic        out_valid_r;
  logic        out_status_r;
  logic signed [31:0] out_result_r;

  logic out_free;
  logic in_acc;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == cf_pkg::ST_IDLE) && out_free;
  assign in_acc = in_chan.valid && in_chan.ready;

  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.result = out_result_r;

  // request range check, done without a divider: row*st + fs <= h + 2*pad
  logic [7:0]  span_h, span_w;
  logic [9:0]  reach_r, reach_c;
  logic        bad_c;

  always_comb begin
    span_h  = 8'(h_c) + 8'({pad_c, 1'b0});
    span_w  = 8'(w_c) + 8'({pad_c, 1'b0});
    reach_r = 10'(row_r) * 10'(st_c) + 10'(fs_c);
    reach_c = 10'(col_r) * 10'(st_c) + 10'(fs_c);
    bad_c   = (reach_r > 10'(span_h)) || (reach_c > 10'(span_w)) ||
              (5'(flt_r) >= nf_c);
  end

  // tap position and counter wrap
  logic [9:0] pr, pc;
  logic       tap_ok;
  logic       j_last, i_last, c_last;

  always_comb begin
    pr = base_r_r + 10'(i_r);
    pc = base_c_r + 10'(j_r);
    tap_ok = (pr >= 10'(pad_c)) && ((pr - 10'(pad_c)) < 10'(h_c)) &&
             (pc >= 10'(pad_c)) && ((pc - 10'(pad_c)) < 10'(w_c));
    j_last = (j_r == fs_c - 3'd1);
    i_last = (i_r == fs_c - 3'd1);
    c_last = (c_r == nc_c - 5'd1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cf_pkg::ST_IDLE: begin
        if (in_acc && cf_pkg::cmd_t'(in_chan.command) == cf_pkg::CMD_COMPUTE) begin
          state_nxt = cf_pkg::ST_CHECK;
        end
      end
      cf_pkg::ST_CHECK:   state_nxt = bad_c ? cf_pkg::ST_FINISH : cf_pkg::ST_RUN;
      cf_pkg::ST_RUN: begin
        if (j_last && i_last && c_last) begin
          state_nxt = cf_pkg::ST_DRAIN_A;
        end
      end
      cf_pkg::ST_DRAIN_A: state_nxt = cf_pkg::ST_DRAIN_B;
      cf_pkg::ST_DRAIN_B: state_nxt = cf_pkg::ST_FINISH;
      cf_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = cf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cf_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  logic                act_we, wgt_we, bias_we;
  logic [ACT_AW-1:0]   act_waddr, act_raddr;
  logic [WGT_AW-1:0]   wgt_waddr, wgt_raddr;
  logic [BIAS_AW-1:0]  bias_waddr, bias_raddr;
  logic [15:0]         sat_val;
  logic [15:0]         act_rdata, wgt_rdata;
  logic [31:0]         bias_rdata;
  cf_pkg::cmd_t        cmd;

  always_comb begin
    cmd = cf_pkg::cmd_t'(in_chan.command);
    if (in_chan.value > 32'sd32767) begin
      sat_val = 16'h7fff;
    end else if (in_chan.value < -32'sd32768) begin
      sat_val = 16'h8000;
    end else begin
      sat_val = in_chan.value[15:0];
    end
    act_we  = in_acc && cmd == cf_pkg::CMD_STORE_ACT &&
              32'(in_chan.row) < MAX_HEIGHT && 32'(in_chan.column) < MAX_WIDTH &&
              32'(in_chan.channel) < MAX_CHANNELS;
    wgt_we  = in_acc && cmd == cf_pkg::CMD_STORE_WGT &&
              32'(in_chan.filter) < MAX_FILTERS &&
              32'(in_chan.channel) < MAX_CHANNELS &&
              32'(in_chan.tap_row) < MAX_FILTER_SIZE &&
              32'(in_chan.tap_column) < MAX_FILTER_SIZE;
    bias_we = in_acc && cmd == cf_pkg::CMD_STORE_BIAS &&
              32'(in_chan.filter) < MAX_FILTERS;
    act_waddr = ACT_AW'((32'(in_chan.row) * MAX_WIDTH + 32'(in_chan.column)) *
                        MAX_CHANNELS + 32'(in_chan.channel));
    wgt_waddr = WGT_AW'(((32'(in_chan.filter) * MAX_CHANNELS + 32'(in_chan.channel)) *
                         MAX_FILTER_SIZE + 32'(in_chan.tap_row)) * MAX_FILTER_SIZE +
                        32'(in_chan.tap_column));
    bias_waddr = BIAS_AW'(in_chan.filter);
    act_raddr = ACT_AW'((32'(pr - 10'(pad_c)) * MAX_WIDTH + 32'(pc - 10'(pad_c))) *
                        MAX_CHANNELS + 32'(c_r));
    wgt_raddr = WGT_AW'(((32'(flt_r) * MAX_CHANNELS + 32'(c_r)) * MAX_FILTER_SIZE +
                         32'(i_r)) * MAX_FILTER_SIZE + 32'(j_r));
    bias_raddr = BIAS_AW'(flt_r);
  end

  cf_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(sat_val),
    .raddr(act_raddr), .rdata_r(act_rdata)
  );

  cf_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(sat_val),
    .raddr(wgt_raddr), .rdata_r(wgt_rdata)
  );

  cf_ram #(.WIDTH(32), .DEPTH(MAX_FILTERS)) u_bias_ram (
    .clk(clk), .we(bias_we), .waddr(bias_waddr), .wdata(in_chan.value),
    .raddr(bias_raddr), .rdata_r(bias_rdata)
  );

  // final saturation to 32 bits
  logic signed [31:0] acc_sat;
  always_comb begin
    if (acc_r > cf_pkg::ACC_W'(64'sd2147483647)) begin
      acc_sat = 32'sh7fffffff;
    end else if (acc_r < -cf_pkg::ACC_W'(64'sd2147483648)) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_r[31:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      bias_load_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= (state_r == cf_pkg::ST_RUN) && tap_ok;
      v2_r        <= v1_r;
      bias_load_r <= (state_r == cf_pkg::ST_CHECK);
      if (in_acc && cmd != cf_pkg::CMD_COMPUTE) begin
        out_valid_r <= 1'b1;
      end else if (state_r == cf_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: window counters, multiply and accumulate
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r <= in_chan.row;
      col_r <= in_chan.column;
      flt_r <= in_chan.filter;
    end
    if (state_r == cf_pkg::ST_CHECK) begin
      bad_r    <= bad_c;
      base_r_r <= 10'(row_r) * 10'(st_c);
      base_c_r <= 10'(col_r) * 10'(st_c);
      c_r <= 5'd0;
      i_r <= 3'd0;
      j_r <= 3'd0;
    end else if (state_r == cf_pkg::ST_RUN) begin
      if (j_last) begin
        j_r <= 3'd0;
        if (i_last) begin
          i_r <= 3'd0;
          c_r <= c_r + 5'd1;
        end else begin
          i_r <= i_r + 3'd1;
        end
      end else begin
        j_r <= j_r + 3'd1;
      end
    end
    prod_r <= $signed(act_rdata) * $signed(wgt_rdata);
    if (bias_load_r) begin
      acc_r <= cf_pkg::ACC_W'($signed(bias_rdata));
    end else if (v2_r) begin
      acc_r <= acc_r + cf_pkg::ACC_W'(prod_r);
    end
    if (in_acc && cmd != cf_pkg::CMD_COMPUTE) begin
      out_status_r <= 1'b0;
      out_result_r <= 32'sd0;
    end else if (state_r == cf_pkg::ST_FINISH && out_free) begin
      out_status_r <= bad_r;
      out_result_r <= bad_r ? 32'sd0 : acc_sat;
    end
  end

endmodule

// File: tb/sv/conv2d_forward_unit_tb.sv
// ----------------------------------------------------------------------------
// conv2d_forward_unit_tb
// Self-checking bench for the convolution engine: drives store and compute
// transactions under random bursts and receiver stalls, predicts each
// result from a local copy of the stores and registers, and compares.
// ----------------------------------------------------------------------------
module conv2d_forward_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // expected result of one transaction
  typedef struct packed {
    logic        status;
    logic [31:0] result;
  } conv_result_t;

  // prediction and checking of results
  class conv_scoreboard;
    logic signed [15:0] act_mem [int];
    logic signed [15:0] wgt_mem [int];
    logic signed [31:0] bias_mem [16];
    int unsigned reg_h, reg_w, reg_ch, reg_nf, reg_fs, reg_st, reg_same;
    conv_result_t pending_q[$];
    int unsigned n_errors, n_checked, n_computes, n_bad;

    function void reset_regs();
      reg_h = 8; reg_w = 8; reg_ch = 1; reg_nf = 1;
      reg_fs = 3; reg_st = 1; reg_same = 1;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        cf_pkg::REG_HEIGHT:   reg_h = d[6:0];
        cf_pkg::REG_WIDTH:    reg_w = d[6:0];
        cf_pkg::REG_CHANNELS: reg_ch = d[4:0];
        cf_pkg::REG_FILTERS:  reg_nf = d[4:0];
        cf_pkg::REG_FSIZE:    reg_fs = d[2:0];
        cf_pkg::REG_STRIDE:   reg_st = d[2:0];
        cf_pkg::REG_SAME:     reg_same = d[0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] sat16(logic signed [31:0] v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return v[15:0];
    endfunction

    function int unsigned span_out(int unsigned n, int unsigned pad, int unsigned fs,
                                   int unsigned st);
      if (n + 2 * pad < fs) return 0;
      return (n + 2 * pad - fs) / st + 1;
    endfunction

    // effective geometry of the current settings
    function void geometry(output int unsigned h, w, nc, nf, fs, st, pad, oh, ow);
      h = clip(reg_h, 64); w = clip(reg_w, 64); nc = clip(reg_ch, 16);
      nf = clip(reg_nf, 16); fs = clip(reg_fs, 7); st = clip(reg_st, 7);
      pad = reg_same ? (fs - 1) / 2 : 0;
      oh = span_out(h, pad, fs, st); ow = span_out(w, pad, fs, st);
    endfunction

    function void note_input(cf_pkg::cmd_t cmd, int unsigned r, c, ch, f, tr, tc,
                             logic signed [31:0] v);
      conv_result_t e;
      int unsigned h, w, nc, nf, fs, st, pad, oh, ow, pr, pc;
      longint acc;
      e = '0;
      case (cmd)
        cf_pkg::CMD_STORE_ACT:  act_mem[(r * 64 + c) * 16 + ch] = sat16(v);
        cf_pkg::CMD_STORE_WGT: begin
          if (tr < 7 && tc < 7) wgt_mem[((f * 16 + ch) * 7 + tr) * 7 + tc] = sat16(v);
        end
        cf_pkg::CMD_STORE_BIAS: bias_mem[f] = v;
        default: begin
          geometry(h, w, nc, nf, fs, st, pad, oh, ow);
          n_computes++;
          if (r >= oh || c >= ow || f >= nf) begin
            e.status = 1'b1;
            n_bad++;
          end else begin
            acc = bias_mem[f];
            for (int unsigned k = 0; k < nc; k++)
              for (int unsigned i = 0; i < fs; i++) begin
                pr = r * st + i;
                if (pr < pad || pr - pad >= h) continue;
                for (int unsigned j = 0; j < fs; j++) begin
                  pc = c * st + j;
                  if (pc < pad || pc - pad >= w) continue;
                  acc += longint'(act_mem[((pr - pad) * 64 + pc - pad) * 16 + k]) *
                         longint'(wgt_mem[((f * 16 + k) * 7 + i) * 7 + j]);
                end
              end
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            e.result = acc[31:0];
          end
        end
      endcase
      pending_q.push_back(e);
    endfunction

    function void check_result(logic st, logic [31:0] res);
      conv_result_t e;
      n_checked++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d result %0h", st, res);
        n_errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) begin
        $error("status mismatch: expected %0d actual %0d", e.status, st);
        n_errors++;
      end
      if (res !== e.result) begin
        $error("result mismatch: expected %0h actual %0h", e.result, res);
        n_errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  cf_in_if  in_chan();
  cf_out_if out_chan();
  cf_cfg_if cfg_chan();

  conv2d_forward_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_chan (cfg_chan.sink)
  );

  conv_scoreboard sb;
  bit hold_off;
  bit stall_on;
  int unsigned n_sent;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // overall watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: patterned stalls, plus one long hold-off on request
  initial begin
    int unsigned phase;
    out_chan.ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) out_chan.ready <= 1'b0;
      else if (!stall_on) out_chan.ready <= 1'b1;
      else out_chan.ready <= ((phase % 7) < 4) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // result monitor
  always @(posedge clk)
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.status, out_chan.result);

  // one input transaction
  task automatic send_item(cf_pkg::cmd_t cmd, int unsigned r, c, ch, f, tr, tc,
                           logic signed [31:0] v);
    in_chan.valid      <= 1'b1;
    in_chan.command    <= cmd;
    in_chan.row        <= r[5:0];
    in_chan.column     <= c[5:0];
    in_chan.channel    <= ch[3:0];
    in_chan.filter     <= f[3:0];
    in_chan.tap_row    <= tr[2:0];
    in_chan.tap_column <= tc[2:0];
    in_chan.value      <= v;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_input(cmd, r, c, ch, f, tr, tc, v);
    n_sent++;
  endtask

  // burst gaps between transactions
  int unsigned burst_left;
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= d;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned h, w, ch, nf, fs, st, same);
    drain();
    write_cfg(cf_pkg::REG_HEIGHT, h);
    write_cfg(cf_pkg::REG_WIDTH, w);
    write_cfg(cf_pkg::REG_CHANNELS, ch);
    write_cfg(cf_pkg::REG_FILTERS, nf);
    write_cfg(cf_pkg::REG_FSIZE, fs);
    write_cfg(cf_pkg::REG_STRIDE, st);
    write_cfg(cf_pkg::REG_SAME, same);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // fill every activation, weight and bias that the geometry can read
  task automatic fill_all(bit random_gaps);
    int unsigned h, w, nc, nf, fs, st, pad, oh, ow;
    sb.geometry(h, w, nc, nf, fs, st, pad, oh, ow);
    for (int unsigned f = 0; f < nf; f++) begin
      if (random_gaps) pace();
      send_item(cf_pkg::CMD_STORE_BIAS, 0, 0, 0, f, 0, 0, rand_value());
      for (int unsigned k = 0; k < nc; k++)
        for (int unsigned i = 0; i < fs; i++)
          for (int unsigned j = 0; j < fs; j++) begin
            if (random_gaps) pace();
            send_item(cf_pkg::CMD_STORE_WGT, 0, 0, k, f, i, j, rand_value());
          end
    end
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++)
        for (int unsigned k = 0; k < nc; k++) begin
          if (random_gaps) pace();
          send_item(cf_pkg::CMD_STORE_ACT, r, c, k, 0, 0, 0, rand_value());
        end
  endtask

  // random computes, some out of range, mixed with re-stores
  task automatic random_mix(int unsigned count);
    int unsigned h, w, nc, nf, fs, st, pad, oh, ow;
    sb.geometry(h, w, nc, nf, fs, st, pad, oh, ow);
    repeat (count) begin
      pace();
      case ($urandom_range(0, 9))
        0: send_item(cf_pkg::CMD_STORE_ACT, $urandom_range(0, h - 1),
                     $urandom_range(0, w - 1),
                     $urandom_range(0, nc - 1), $urandom_range(0, 15), $urandom_range(0, 7),
                     $urandom_range(0, 7), rand_value());
        1: send_item(cf_pkg::CMD_STORE_WGT, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, nc - 1), $urandom_range(0, nf - 1),
                     $urandom_range(0, fs - 1), $urandom_range(0, fs - 1), rand_value());
        2: send_item(cf_pkg::CMD_STORE_BIAS, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), $urandom_range(0, nf - 1), 0, 0, rand_value());
        3: send_item(cf_pkg::CMD_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                     $urandom_range(0, 7), $urandom());
        default: send_item(cf_pkg::CMD_COMPUTE, (oh == 0) ? 0 : $urandom_range(0, oh - 1),
                           (ow == 0) ? 0 : $urandom_range(0, ow - 1), $urandom_range(0, 15),
                           $urandom_range(0, nf - 1), $urandom_range(0, 7),
                           $urandom_range(0, 7), $urandom());
      endcase
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    sb.reset_regs();
    n_sent = 0;
    burst_left = 0;
    hold_off = 1'b0;
    stall_on = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = cf_pkg::CMD_STORE_ACT;
    in_chan.row = '0;
    in_chan.column = '0;
    in_chan.channel = '0;
    in_chan.filter = '0;
    in_chan.tap_row = '0;
    in_chan.tap_column = '0;
    in_chan.value = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = cf_pkg::REG_HEIGHT;
    cfg_chan.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset geometry, store extremes, corner computes, bad requests
    fill_all(1'b0);
    send_item(cf_pkg::CMD_STORE_ACT, 0, 0, 0, 0, 0, 0, 32'sh7fffffff);
    send_item(cf_pkg::CMD_STORE_ACT, 7, 7, 0, 0, 0, 0, 32'sh80000000);
    send_item(cf_pkg::CMD_STORE_WGT, 0, 0, 0, 0, 7, 7, 32'sh12345678);
    send_item(cf_pkg::CMD_STORE_WGT, 0, 0, 0, 0, 2, 2, -32'sd40000);
    send_item(cf_pkg::CMD_STORE_BIAS, 0, 0, 0, 15, 0, 0, 32'sh80000000);
    send_item(cf_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
    send_item(cf_pkg::CMD_COMPUTE, 7, 7, 0, 0, 0, 0, 0);
    send_item(cf_pkg::CMD_COMPUTE, 8, 0, 0, 0, 0, 0, 0);
    send_item(cf_pkg::CMD_COMPUTE, 0, 63, 0, 0, 0, 0, 0);
    send_item(cf_pkg::CMD_COMPUTE, 0, 0, 0, 1, 0, 0, 0);
    send_item(cf_pkg::CMD_COMPUTE, 63, 63, 15, 15, 7, 7, 32'hffffffff);

    // saturation: full-scale products over 3x3 taps
    set_geometry(4, 4, 1, 1, 3, 1, 1);
    fill_all(1'b0);
    for (int unsigned k = 0; k < 1; k++) begin
      for (int unsigned i = 0; i < 3; i++)
        for (int unsigned j = 0; j < 3; j++)
          send_item(cf_pkg::CMD_STORE_WGT, 0, 0, k, 0, i, j, 32'sh7fffffff);
      for (int unsigned r = 0; r < 4; r++)
        for (int unsigned c = 0; c < 4; c++)
          send_item(cf_pkg::CMD_STORE_ACT, r, c, k, 0, 0, 0, 32'sh7fffffff);
    end
    send_item(cf_pkg::CMD_COMPUTE, 1, 1, 0, 0, 0, 0, 0);
    for (int unsigned k = 0; k < 1; k++)
      for (int unsigned i = 0; i < 3; i++)
        for (int unsigned j = 0; j < 3; j++)
          send_item(cf_pkg::CMD_STORE_WGT, 0, 0, k, 0, i, j, 32'sh80000000);
    send_item(cf_pkg::CMD_COMPUTE, 1, 1, 0, 0, 0, 0, 0);

    // long receiver hold-off while the sender keeps offering
    stall_on = 1'b1;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      random_mix(30);
    join

    // register corners, including out-of-range values that clamp
    set_geometry(1, 1, 1, 1, 1, 1, 0);
    fill_all(1'b1);
    random_mix(20);
    set_geometry(0, 127, 0, 31, 0, 0, 1);
    fill_all(1'b1);
    random_mix(20);
    set_geometry(3, 5, 1, 2, 7, 7, 1);
    fill_all(1'b1);
    random_mix(30);

    // random geometries, mostly small
    while (n_sent < 560) begin
      stall_on = $urandom_range(0, 1);
      set_geometry($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 2),
                   $urandom_range(1, 2), $urandom_range(1, 7), $urandom_range(1, 4),
                   $urandom_range(0, 1));
      fill_all(1'b1);
      random_mix(60);
    end
    // one tall image, sparse computes
    set_geometry(64, 2, 1, 1, 2, 7, 1);
    fill_all(1'b1);
    random_mix(10);

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d transactions, %0d computes (%0d out of range), %0d results checked.",
             n_sent, sb.n_computes, sb.n_bad, sb.n_checked);
    $display("Geometry corners, clamped registers, saturation and a long output stall run.");
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
